// ===== rtl/traffic_light_with_hold_buttons_unit_macros.svh =====
// ----------------------------------------------------------------------------
// traffic light unit assertion macros
// shared concurrent assertion forms, clocked on clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef TRAFFIC_LIGHT_WITH_HOLD_BUTTONS_UNIT_MACROS_SVH
`define TRAFFIC_LIGHT_WITH_HOLD_BUTTONS_UNIT_MACROS_SVH

// same-cycle implication
`define TLHB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TLHB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tlhb_pkg.sv =====
// ----------------------------------------------------------------------------
// tlhb_pkg
// shared types, register codes and helpers of the traffic light unit
// ----------------------------------------------------------------------------
package tlhb_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int CFG_W       = 32;
	localparam int CFG_INDEX_W = 8;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;
	typedef logic [CFG_W-1:0]       cfg_word_t;
	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	localparam cnt_t CNT_MAX = '1;

	// register indexes
	localparam cfg_index_t REG_HOLD_TICKS   = 8'd0;
	localparam cfg_index_t REG_PERIOD_TICKS = 8'd1;

	localparam cfg_word_t HOLD_TICKS_RESET   = 32'd32000000;
	localparam cfg_word_t PERIOD_TICKS_RESET = 32'd80000000;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_STOP = 2'd1,
		PH_GO   = 2'd2,
		PH_WARN = 2'd3
	} phase_t;

	// control from the top level to one button hold counter
	typedef struct packed {
		logic step;
		logic level;
		logic move;
		logic reload_on_move;
	} hold_ctl_t;

	// reload value, saturated to the counter range
	function automatic cnt_t load_value(cfg_word_t v);
		logic [64:0] wide_v;
		logic [64:0] wide_max;
		wide_v   = 65'(v);
		wide_max = 65'(CNT_MAX);
		if (wide_v > wide_max) begin
			return CNT_MAX;
		end
		return cnt_t'(v);
	endfunction

endpackage

// ===== rtl/tlhb_if.sv =====
// ----------------------------------------------------------------------------
// traffic light unit channels
// button item channel, lamp item channel and register write channel
// ----------------------------------------------------------------------------
interface tlhb_in_if;
	logic valid;
	logic ready;
	logic start_stop_level;
	logic walk_level;

	modport source (output valid, output start_stop_level, output walk_level, input ready);
	modport sink (input valid, input start_stop_level, input walk_level, output ready);
endinterface

interface tlhb_out_if;
	logic       valid;
	logic       ready;
	logic       red_lamp;
	logic       yellow_lamp;
	logic       green_lamp;
	logic [1:0] light_state;

	modport source (output valid, output red_lamp, output yellow_lamp, output green_lamp,
		output light_state, input ready);
	modport sink (input valid, input red_lamp, input yellow_lamp, input green_lamp,
		input light_state, output ready);
endinterface

interface tlhb_cfg_if;
	logic                   valid;
	logic                   ready;
	tlhb_pkg::cfg_index_t   index;
	tlhb_pkg::cfg_word_t    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tlhb_hold.sv =====
// ----------------------------------------------------------------------------
// tlhb_hold
// one button hold counter with its press latch
// ----------------------------------------------------------------------------
`include "traffic_light_with_hold_buttons_unit_macros.svh"

module tlhb_hold (
	input  logic                clk,
	input  logic                arst_n,
	input  tlhb_pkg::hold_ctl_t ctl,
	input  tlhb_pkg::cfg_word_t hold_ticks,
	output logic                latched
);

	tlhb_pkg::cnt_t count_q;
	logic           running_q;
	logic           latched_q;

	tlhb_pkg::cnt_t load_d;
	tlhb_pkg::cnt_t count_tick;
	tlhb_pkg::cnt_t count_smp;
	logic           fire;

	always_comb begin
		load_d = tlhb_pkg::load_value(hold_ticks);
		fire   = running_q && (count_q <= tlhb_pkg::cnt_t'(1));
		// expire reloads, running counts down, stopped holds
		if (fire) begin
			count_tick = load_d;
		end else if (running_q) begin
			count_tick = count_q - tlhb_pkg::cnt_t'(1);
		end else begin
			count_tick = count_q;
		end
		// low level stops and reloads
		count_smp = ctl.level ? count_tick : load_d;
		latched   = latched_q | fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= tlhb_pkg::load_value(tlhb_pkg::HOLD_TICKS_RESET);
			running_q <= 1'b0;
			latched_q <= 1'b0;
		end else if (ctl.step) begin
			running_q <= ctl.level;
			latched_q <= latched & ~ctl.move;
			count_q   <= (ctl.move && ctl.reload_on_move) ? load_d : count_smp;
		end
	end

	`TLHB_ASSERT_NEXT(a_low_stops, ctl.step && !ctl.level, !running_q,
		"hold counter still running after low level")
	`TLHB_ASSERT_NEXT(a_move_clears, ctl.step && ctl.move, !latched_q,
		"press latch survived a light transition")
	`TLHB_ASSERT_NEXT(a_expire_sets, ctl.step && fire && !ctl.move, latched_q,
		"expired hold counter did not set its latch")

endmodule

// ===== rtl/traffic_light_with_hold_buttons_unit.sv =====
// ----------------------------------------------------------------------------
// traffic_light_with_hold_buttons_unit
// four-phase traffic light with held start/stop and pedestrian buttons
// ----------------------------------------------------------------------------
// Each item on items is one timer tick carrying the two button levels; each
// tick gives exactly one lamp item on results showing the phase held before
// that tick. The unit takes one item every clock cycle while results.ready
// holds or the result register is empty: an item is caught in an input
// register, the counter and phase update is done in one pass of short logic
// (a 32-bit decrement and compare per counter plus the phase decision), and
// the lamps land in an output register once it is free or being drained; a
// stalled result register still lets one more item wait in the input stage. A
// button registers once held for hold_ticks ticks and stays latched until
// the next transition; the period timer forces a transition every
// period_ticks ticks. A count register of 0 acts as 1. Register writes are
// taken at once (cfg.ready is always high) and take effect at the next
// reload of the counter concerned.
// ----------------------------------------------------------------------------
`include "traffic_light_with_hold_buttons_unit_macros.svh"

module traffic_light_with_hold_buttons_unit (
	input  logic         clk,
	input  logic         arst_n,
	tlhb_in_if.sink      items,
	tlhb_out_if.source   results,
	tlhb_cfg_if.sink     cfg
);

	// configuration registers
	tlhb_pkg::cfg_word_t hold_ticks_q;
	tlhb_pkg::cfg_word_t period_ticks_q;

	// input stage
	logic valid_s1;
	logic start_stop_s1;
	logic walk_s1;

	// light state
	tlhb_pkg::phase_t phase_q;
	tlhb_pkg::cnt_t   period_count_q;

	// result register
	logic       out_valid_q;
	logic       red_q;
	logic       yellow_q;
	logic       green_q;
	logic [1:0] state_q;

	logic advance;
	logic step;
	logic period_fire;
	logic move;
	logic walk_latched;
	logic run_latched;

	tlhb_pkg::phase_t  next_phase;
	logic              red_d;
	logic              yellow_d;
	logic              green_d;
	tlhb_pkg::hold_ctl_t walk_ctl;
	tlhb_pkg::hold_ctl_t run_ctl;

	// register writes, never stalled
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q   <= tlhb_pkg::HOLD_TICKS_RESET;
			period_ticks_q <= tlhb_pkg::PERIOD_TICKS_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tlhb_pkg::REG_HOLD_TICKS:   hold_ticks_q   <= cfg.data;
				tlhb_pkg::REG_PERIOD_TICKS: period_ticks_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// the input stage moves on whenever the result register is free or being drained
	assign advance     = !out_valid_q || results.ready;
	assign items.ready = !valid_s1 || advance;
	assign step        = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			start_stop_s1 <= items.start_stop_level;
			walk_s1       <= items.walk_level;
		end
	end

	// button hold counters; the start/stop counter keeps its count across transitions
	assign walk_ctl = '{step: step, level: walk_s1, move: move, reload_on_move: 1'b1};
	assign run_ctl  = '{step: step, level: start_stop_s1, move: move, reload_on_move: 1'b0};

	tlhb_hold u_walk_hold (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (walk_ctl),
		.hold_ticks (hold_ticks_q),
		.latched    (walk_latched)
	);

	tlhb_hold u_run_hold (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (run_ctl),
		.hold_ticks (hold_ticks_q),
		.latched    (run_latched)
	);

	// period timer expires at a count of one or zero
	assign period_fire = period_count_q <= tlhb_pkg::cnt_t'(1);

	// next phase and whether a transition happens this tick
	always_comb begin
		next_phase = phase_q;
		move       = period_fire;
		unique case (phase_q)
			tlhb_pkg::PH_IDLE: begin
				// start press leaves idle without waiting for the timer
				if (run_latched) begin
					next_phase = tlhb_pkg::PH_STOP;
					move       = 1'b1;
				end
			end
			tlhb_pkg::PH_STOP: begin
				next_phase = run_latched ? tlhb_pkg::PH_IDLE : tlhb_pkg::PH_GO;
			end
			tlhb_pkg::PH_GO: begin
				if (run_latched) begin
					next_phase = tlhb_pkg::PH_IDLE;
				end else if (walk_latched) begin
					// pedestrian request cuts go short
					next_phase = tlhb_pkg::PH_WARN;
					move       = 1'b1;
				end else begin
					next_phase = tlhb_pkg::PH_STOP;
				end
			end
			tlhb_pkg::PH_WARN: begin
				next_phase = run_latched ? tlhb_pkg::PH_IDLE : tlhb_pkg::PH_STOP;
			end
			default: ;
		endcase
	end

	// lamps follow the phase held at the start of the tick
	always_comb begin
		red_d    = 1'b0;
		yellow_d = 1'b0;
		green_d  = 1'b0;
		unique case (phase_q)
			tlhb_pkg::PH_IDLE: ;
			tlhb_pkg::PH_STOP: red_d    = 1'b1;
			tlhb_pkg::PH_GO:   green_d  = 1'b1;
			tlhb_pkg::PH_WARN: yellow_d = 1'b1;
			default: ;
		endcase
	end

	// phase and period timer; any transition reloads the timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= tlhb_pkg::PH_IDLE;
			period_count_q <= tlhb_pkg::load_value(tlhb_pkg::PERIOD_TICKS_RESET);
		end else if (step) begin
			if (move) begin
				phase_q        <= next_phase;
				period_count_q <= tlhb_pkg::load_value(period_ticks_q);
			end else begin
				period_count_q <= period_count_q - tlhb_pkg::cnt_t'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			red_q    <= red_d;
			yellow_q <= yellow_d;
			green_q  <= green_d;
			state_q  <= phase_q;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.red_lamp    = red_q;
	assign results.yellow_lamp = yellow_q;
	assign results.green_lamp  = green_q;
	assign results.light_state = state_q;

	`TLHB_ASSERT_NEXT(a_step_gives_item, step, results.valid,
		"processed tick did not produce a lamp item")
	`TLHB_ASSERT_NEXT(a_state_matches, step, results.light_state == $past(phase_q),
		"lamp item does not show the phase before the tick")
	`TLHB_ASSERT_NEXT(a_walk_to_warn,
		step && phase_q == tlhb_pkg::PH_GO && !run_latched && walk_latched,
		phase_q == tlhb_pkg::PH_WARN,
		"pedestrian press in go did not move to warn")

endmodule
